### design/wavelet_tree_query_engine_assert.svh
// ---------------------------------------------------------------------------
// Wavelet tree query engine assertion macros
// Short helpers for the concurrent checks of the query engine.
// ---------------------------------------------------------------------------
`ifndef WAVELET_TREE_QUERY_ENGINE_ASSERT_SVH
`define WAVELET_TREE_QUERY_ENGINE_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define WTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that is checked also while reset is high.
`define WTQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/wtq_pkg.sv
// ---------------------------------------------------------------------------
// Wavelet tree query engine package
// Sizes, operation codes, status codes and the word types of the engine.
// ---------------------------------------------------------------------------
package wtq_pkg;

  localparam int CAPACITY    = 4096;
  localparam int SYMBOL_BITS = 8;
  localparam int ALPHA_SIZE  = 1 << SYMBOL_BITS;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int LEN_W       = 13;
  localparam int SYM_W       = 9;

  typedef enum logic [2:0] {
    OP_CLEAR       = 3'd0,
    OP_APPEND      = 3'd1,
    OP_ACCESS      = 3'd2,
    OP_RANK        = 3'd3,
    OP_RANK_BELOW  = 3'd4,
    OP_SELECT      = 3'd5,
    OP_FREQ        = 3'd6,
    OP_RANGE_COUNT = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]       operation;
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] symbol_high;
    logic [LEN_W-1:0] position;
    logic [LEN_W-1:0] position_end;
    logic [LEN_W-1:0] occurrence;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] value;
    logic [1:0]       status;
  } out_word_t;

  // Classified command: the original operands plus the scan window.
  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] shi;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] pend;
    logic [LEN_W-1:0] occ;
    logic [LEN_W-1:0] from;
    logic [LEN_W-1:0] to;
    logic [SYM_W-1:0] lo;
    logic [SYM_W:0]   hi;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACC,
    S_SCAN,
    S_OUT
  } back_state_t;

endpackage

### design/wtq_front.sv
// ---------------------------------------------------------------------------
// Query engine front end
// Accepts request words and turns them into commands with a scan window.
// ---------------------------------------------------------------------------
module wtq_front import wtq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t request,
  output logic     cmd_push,
  input  logic     cmd_full,
  output cmd_t     cmd_out
);

  logic stage_v;
  cmd_t stage;
  cmd_t cls;
  logic accept;

  // Classify the incoming word.
  always_comb begin
    cls       = '0;
    cls.op    = op_t'(request.operation);
    cls.sym   = request.symbol;
    cls.shi   = request.symbol_high;
    cls.pos   = request.position;
    cls.pend  = request.position_end;
    cls.occ   = request.occurrence;
    cls.from  = '0;
    cls.to    = request.position;
    cls.lo    = request.symbol;
    cls.hi    = {1'b0, request.symbol} + 10'd1;
    case (op_t'(request.operation))
      OP_RANK_BELOW: begin
        cls.lo = '0;
        cls.hi = {1'b0, request.symbol};
      end
      OP_SELECT: begin
        cls.to = LEN_W'(CAPACITY);
      end
      OP_RANGE_COUNT: begin
        cls.from = request.position;
        cls.to   = request.position_end;
        cls.hi   = {1'b0, request.symbol_high};
      end
      default: begin
      end
    endcase
  end

  assign full     = stage_v && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = stage_v && !cmd_full;
  assign cmd_out  = stage;

  // One holding stage in front of the command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else if (accept) begin
      stage_v <= 1'b1;
    end else if (cmd_push) begin
      stage_v <= 1'b0;
    end
    if (accept) begin
      stage <= cls;
    end
  end

endmodule

### design/wtq_cmd_fifo.sv
// ---------------------------------------------------------------------------
// Query engine command queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module wtq_cmd_fifo import wtq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd,
  output logic q_valid,
  output cmd_t rd_data
);

  cmd_t       entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign q_full  = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign rd_data = entries[rp];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wp <= ~wp;
      end
      if (rd && q_valid) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(wr && !q_full) - 2'(rd && q_valid);
    end
    if (wr && !q_full) begin
      entries[wp] <= wr_data;
    end
  end

endmodule

### design/wtq_back.sv
// ---------------------------------------------------------------------------
// Query engine back end
// Holds the symbol store and counts, checks and executes one command at a
// time, and keeps the result word until it is taken.
// ---------------------------------------------------------------------------
module wtq_back import wtq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t response
);

  back_state_t state;
  back_state_t state_next;

  logic [SYMBOL_BITS-1:0] sym_mem [CAPACITY];
  logic [LEN_W-1:0]       cnt_mem [ALPHA_SIZE];
  logic [ALPHA_SIZE-1:0]  cnt_valid;

  cmd_t                   cmd;
  logic [LEN_W-1:0]       len;
  logic [SYM_W-1:0]       alph;
  logic [SYMBOL_BITS-1:0] sym_rd;
  logic [LEN_W-1:0]       cnt_rd;
  logic                   cnt_rd_v;
  logic [LEN_W-1:0]       idx;
  logic [LEN_W-1:0]       scan_to;
  logic                   rd_v;
  logic [LEN_W-1:0]       rd_pos;
  logic [LEN_W-1:0]       count;
  logic [LEN_W-1:0]       hit_pos;
  out_word_t              pend;
  out_word_t              res;
  logic                   res_v;

  logic [LEN_W-1:0]       cnt_cur;
  logic [1:0]             chk_status;
  logic [LEN_W-1:0]       chk_value;
  logic                   scan_issue;
  logic                   scan_done;
  logic                   scan_match;
  logic                   out_load;
  logic                   app_ok;
  logic [ADDR_W-1:0]      rd_addr;

  assign cnt_cur    = cnt_rd_v ? cnt_rd : '0;
  assign scan_match = ({1'b0, sym_rd} >= cmd.lo) && ({2'b0, sym_rd} < cmd.hi);
  assign scan_done  = !scan_issue && !rd_v;
  assign empty      = !res_v;
  assign response   = res;

  // Operand checks against the current store state.
  always_comb begin
    chk_status = ST_OK;
    chk_value  = '0;
    case (cmd.op)
      OP_APPEND: begin
        if (len >= LEN_W'(CAPACITY)) begin
          chk_status = ST_FULL;
        end else if (cmd.sym >= SYM_W'(ALPHA_SIZE)) begin
          chk_status = ST_NOT_FOUND;
        end
      end
      OP_ACCESS: begin
        if (cmd.pos >= len) chk_status = ST_NOT_FOUND;
      end
      OP_RANK: begin
        if (cmd.sym >= alph || cmd.pos > len) chk_status = ST_NOT_FOUND;
      end
      OP_RANK_BELOW: begin
        if (cmd.sym > alph || cmd.pos > len) chk_status = ST_NOT_FOUND;
      end
      OP_SELECT: begin
        if (cmd.sym >= alph || cmd.occ == '0 || cmd.occ > cnt_cur) begin
          chk_status = ST_NOT_FOUND;
        end
      end
      OP_FREQ: begin
        if (cmd.sym >= alph) chk_status = ST_NOT_FOUND;
        else chk_value = cnt_cur;
      end
      OP_RANGE_COUNT: begin
        if (cmd.shi > alph || cmd.pend > len || cmd.sym > cmd.shi ||
            cmd.pos > cmd.pend) begin
          chk_status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign app_ok = (state == S_EXEC) && (cmd.op == OP_APPEND) && (chk_status == ST_OK);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (chk_status != ST_OK) begin
          state_next = S_OUT;
        end else if (cmd.op == OP_ACCESS) begin
          state_next = S_ACC;
        end else if (cmd.op == OP_RANK || cmd.op == OP_RANK_BELOW ||
                     cmd.op == OP_SELECT || cmd.op == OP_RANGE_COUNT) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_ACC: state_next = S_OUT;
      S_SCAN: begin
        if (scan_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!res_v || pop) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop      = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    rd_addr    = idx[ADDR_W-1:0];
    case (state)
      S_IDLE: q_pop = q_valid;
      S_EXEC: rd_addr = cmd.pos[ADDR_W-1:0];
      S_SCAN: scan_issue = idx < scan_to;
      S_OUT:  out_load = !res_v || pop;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Symbol store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (app_ok) begin
      sym_mem[len[ADDR_W-1:0]] <= cmd.sym[SYMBOL_BITS-1:0];
    end
    sym_rd <= sym_mem[rd_addr];
  end

  // Symbol count memory, read while the command is taken.
  always_ff @(posedge clk) begin
    if (app_ok) begin
      cnt_mem[cmd.sym[SYMBOL_BITS-1:0]] <= cnt_cur + 1'b1;
    end
    cnt_rd   <= cnt_mem[q_cmd.sym[SYMBOL_BITS-1:0]];
    cnt_rd_v <= cnt_valid[q_cmd.sym[SYMBOL_BITS-1:0]];
  end

  // Store state: length, alphabet and count valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      alph      <= '0;
      cnt_valid <= '0;
    end else if (state == S_EXEC && cmd.op == OP_CLEAR) begin
      len       <= '0;
      alph      <= '0;
      cnt_valid <= '0;
    end else if (app_ok) begin
      len <= len + 1'b1;
      cnt_valid[cmd.sym[SYMBOL_BITS-1:0]] <= 1'b1;
      if (cmd.sym + 1'b1 > alph) begin
        alph <= cmd.sym + 1'b1;
      end
    end
  end

  // Command capture and the scan over the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= scan_issue;
    end
    rd_pos <= idx;
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (state == S_EXEC) begin
      idx     <= cmd.from;
      scan_to <= (cmd.to < len) ? cmd.to : len;
      count   <= '0;
      hit_pos <= '0;
      pend    <= '{value: chk_value, status: chk_status};
    end
    if (scan_issue) begin
      idx <= idx + 1'b1;
    end
    if (state == S_SCAN && rd_v && scan_match) begin
      count <= count + 1'b1;
      if (count + 1'b1 == cmd.occ) begin
        hit_pos <= rd_pos;
      end
    end
    if (state == S_ACC) begin
      pend <= '{value: LEN_W'(sym_rd), status: ST_OK};
    end
    if (state == S_SCAN && scan_done) begin
      pend <= '{value: (cmd.op == OP_SELECT) ? hit_pos : count, status: ST_OK};
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (out_load) begin
      res_v <= 1'b1;
    end else if (pop && res_v) begin
      res_v <= 1'b0;
    end
    if (out_load) begin
      res <= pend;
    end
  end

endmodule

### design/wavelet_tree_query_engine.sv
// Rank, rank_below, select and range_count scan the symbol store one entry
// per cycle through its single read port, over a window of positions: the
// prefix below position (range_count: position to position_end; select:
// the whole sequence).
// The back end executes one word at a time; up to three words queue.
// Reset (synchronous, rst high) empties queues, sequence and counts.
// ---------------------------------------------------------------------------
// Wavelet tree query engine
// Rank, select, access and range counting over an appended symbol sequence.
// ---------------------------------------------------------------------------
module wavelet_tree_query_engine import wtq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  request,
  output logic      empty,
  input  logic      pop,
  output out_word_t response
);

  logic cmd_push;
  logic cmd_full;
  cmd_t cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  wtq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd_out  (cmd_in)
  );

  wtq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .q_full  (cmd_full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_data (q_cmd)
  );

  wtq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .response (response)
  );

endmodule

### design/wtq_checker.sv
// ---------------------------------------------------------------------------
// Query engine port checker
// Concurrent checks on the ports of the query engine.
// ---------------------------------------------------------------------------
`include "wavelet_tree_query_engine_assert.svh"

module wtq_checker import wtq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_word_t  request,
  input logic      empty,
  input logic      pop,
  input out_word_t response
);

  // A shown word never carries the unused status code.
  `WTQ_ASSERT(a_status_code, !empty |-> response.status != 2'd3, "bad status code")

  // A failed word carries a zero value.
  `WTQ_ASSERT(a_zero_on_fail, (!empty && response.status != ST_OK) |-> response.value == '0, "nonzero value")

  // A waiting word holds until it is taken.
  `WTQ_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(response)), "word changed")

  // After reset, no word is shown and input is open.
  `WTQ_ASSERT_RST(a_reset, rst |=> (empty && !full), "not empty after reset")

endmodule

bind wavelet_tree_query_engine wtq_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .request  (request),
  .empty    (empty),
  .pop      (pop),
  .response (response)
);
